>>> rtl/core/lru_must_may_cache_update_macros.svh
// assertion macros for the must/may lru cache update block
`ifndef LRU_MUST_MAY_CACHE_UPDATE_MACROS_SVH
`define LRU_MUST_MAY_CACHE_UPDATE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define LMMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lmmc check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define LMMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lmmc check failed");

`endif

>>> rtl/core/lmmc_pkg.sv
// shared types and constants for the must/may lru cache update block
`default_nettype none

package lmmc_pkg;

  localparam int unsigned Lines    = 8;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned AgeW     = 3;
  localparam int unsigned FillW    = 4;
  localparam int unsigned LineCntW = 4;

  localparam logic [LineCntW-1:0] LineCntReset = LineCntW'(Lines);

  // one entry as it moves down the row
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] tag;
  } cell_state_t;

  // per-request control broadcast to every cell
  typedef struct packed {
    logic             step;
    logic             set_hit;
    logic [AddrW-1:0] addr;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/lru_must_may_cache_update.sv
// Must/may abstract LRU cache classifier. Each request carries one line address and
// updates both sets: every set is a row of eight cells ordered by age, the address is
// compared in all cells at once and the row shifts down toward the hit position (or all
// the way on a miss, dropping entries that reach the line count). One request is taken
// per clock when not stalled; the result sits in an output register, so a new request is
// taken in the same cycle the previous result is taken. The tag compare and shift across
// the cell row sets the cycle time. line_count may only be written while idle.
`default_nettype none

module lru_must_may_cache_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lmmc_pkg::LineCntW-1:0] cfg_line_count_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lmmc_pkg::AddrW-1:0]    access_line_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          must_hit_o,
  output logic                          may_hit_o,
  output logic [lmmc_pkg::AgeW-1:0]     must_prior_age_o,
  output logic [lmmc_pkg::FillW-1:0]    must_fill_o,
  output logic [lmmc_pkg::FillW-1:0]    may_fill_o
);

  logic [lmmc_pkg::LineCntW-1:0] line_count_q;
  logic                          out_valid_q, out_valid_d;
  logic                          step;
  logic                          must_hit, may_hit;
  logic [lmmc_pkg::AgeW-1:0]     must_age, may_age;
  logic [lmmc_pkg::FillW-1:0]    must_fill, may_fill;
  logic                          must_hit_q, may_hit_q;
  logic [lmmc_pkg::AgeW-1:0]     must_age_q;
  logic [lmmc_pkg::FillW-1:0]    must_fill_q, may_fill_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= lmmc_pkg::LineCntReset;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        line_count_q <= cfg_line_count_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  lmmc_row u_must (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .addr_i       (access_line_address_i),
    .line_count_i (line_count_q),
    .hit_o        (must_hit),
    .age_o        (must_age),
    .fill_o       (must_fill)
  );

  // with unique ages the inclusive may rule moves the same entries as the must rule
  lmmc_row u_may (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .addr_i       (access_line_address_i),
    .line_count_i (line_count_q),
    .hit_o        (may_hit),
    .age_o        (may_age),
    .fill_o       (may_fill)
  );

  always_ff @(posedge clk_i) begin
    if (step) begin
      must_hit_q  <= must_hit;
      may_hit_q   <= may_hit && (may_age == may_age);
      must_age_q  <= must_age;
      must_fill_q <= must_fill;
      may_fill_q  <= may_fill;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign must_hit_o       = must_hit_q;
  assign may_hit_o        = may_hit_q;
  assign must_prior_age_o = must_age_q;
  assign must_fill_o      = must_fill_q;
  assign may_fill_o       = may_fill_q;

endmodule

`default_nettype wire

>>> rtl/core/lmmc_cell.sv
// one lru stack position: holds the entry whose age equals its place in the row
`default_nettype none

module lmmc_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lmmc_pkg::cell_ctrl_t ctrl_i,
  input  lmmc_pkg::cell_state_t prev_i,
  input  logic                 in_limit_i,
  input  logic                 hit_above_i,
  output logic                 hit_above_o,
  output logic                 match_o,
  output logic                 valid_nxt_o,
  output lmmc_pkg::cell_state_t state_o
);

  logic                       valid_q, valid_d;
  logic [lmmc_pkg::AddrW-1:0] tag_q, tag_d;
  logic                       shift;

  always_comb begin
    match_o     = valid_q && (tag_q == ctrl_i.addr);
    hit_above_o = hit_above_i | match_o;
    // cells at or above the hit position (all of them on a miss) take the younger entry
    shift       = !hit_above_i;
    // on a miss the entry moved here ages out once it reaches the line count
    valid_d     = shift ? (prev_i.valid && (ctrl_i.set_hit || in_limit_i)) : valid_q;
    tag_d       = shift ? prev_i.tag : tag_q;
    valid_nxt_o = valid_d;
    state_o     = '{valid: valid_q, tag: tag_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.step) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step && valid_d) begin
      tag_q <= tag_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lmmc_row.sv
// one abstract lru set: a row of cells ordered by age, youngest first
`default_nettype none

module lmmc_row (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [lmmc_pkg::AddrW-1:0]    addr_i,
  input  logic [lmmc_pkg::LineCntW-1:0] line_count_i,
  output logic                          hit_o,
  output logic [lmmc_pkg::AgeW-1:0]     age_o,
  output logic [lmmc_pkg::FillW-1:0]    fill_o
);

  localparam int unsigned N = lmmc_pkg::Lines;

  lmmc_pkg::cell_ctrl_t  ctrl;
  lmmc_pkg::cell_state_t link [N+1];
  logic [N:0]            above;
  logic [N-1:0]          match;
  logic [N-1:0]          valid_nxt;
  logic [N-1:0]          in_limit;

  assign above[0] = 1'b0;
  assign hit_o    = above[N];
  // the new address always enters at the top
  assign link[0]  = '{valid: 1'b1, tag: addr_i};

  always_comb begin
    ctrl.step    = step_i;
    ctrl.set_hit = above[N];
    ctrl.addr    = addr_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    // the top cell holds the new entry even with a zero line count
    assign in_limit[i] = (i == 0) || (lmmc_pkg::LineCntW'(i) < line_count_i);

    lmmc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_i      (link[i]),
      .in_limit_i  (in_limit[i]),
      .hit_above_i (above[i]),
      .hit_above_o (above[i+1]),
      .match_o     (match[i]),
      .valid_nxt_o (valid_nxt[i]),
      .state_o     (link[i+1])
    );
  end

  always_comb begin
    age_o  = '0;
    fill_o = '0;
    for (int unsigned i = 0; i < N; i++) begin
      if (match[i] && !above[i]) begin
        age_o = age_o | lmmc_pkg::AgeW'(i);
      end
      fill_o = fill_o + lmmc_pkg::FillW'(valid_nxt[i]);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lmmc_checker.sv
// port-level checks for the must/may lru cache update block
`default_nettype none

`include "lru_must_may_cache_update_macros.svh"

module lmmc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          must_hit_o,
  input logic                          may_hit_o,
  input logic [lmmc_pkg::AgeW-1:0]     must_prior_age_o,
  input logic [lmmc_pkg::FillW-1:0]    must_fill_o,
  input logic [lmmc_pkg::FillW-1:0]    may_fill_o
);

  logic [2+lmmc_pkg::AgeW+2*lmmc_pkg::FillW-1:0] result_view;
  logic                                          fill_ok;

  assign result_view = {must_hit_o, may_hit_o, must_prior_age_o, must_fill_o, may_fill_o};
  // a set is never empty right after an access
  assign fill_ok = (must_fill_o != '0) &&
                   (must_fill_o <= lmmc_pkg::FillW'(lmmc_pkg::Lines)) &&
                   (may_fill_o != '0);

  `LMMC_ASSERT_NEXT(a_result_after_request, in_valid_i && in_ready_o, out_valid_o)
  `LMMC_ASSERT_NEXT(a_result_held, out_valid_o && !out_ready_i, out_valid_o && $stable(result_view))
  `LMMC_ASSERT_NOW(a_must_in_may, out_valid_o && must_hit_o, may_hit_o)
  `LMMC_ASSERT_NOW(a_miss_age_zero, out_valid_o && !must_hit_o, must_prior_age_o == '0)
  `LMMC_ASSERT_NOW(a_fill_range, out_valid_o, fill_ok)

endmodule

bind lru_must_may_cache_update lmmc_checker u_lmmc_checker (.*);

`default_nettype wire
